// File: rtl/core/j2gp_pkg.sv
`default_nettype none
package j2gp_pkg;

  localparam int NCOMP    = 3;
  localparam int POS_W    = 28;
  localparam int R2_W     = 2 * POS_W;
  localparam int R2H_W    = R2_W / 2;
  localparam int R4_W     = 2 * R2_W;
  localparam int SQ_PAD   = 8;
  localparam int SQ_IN_W  = R2_W + SQ_PAD;
  localparam int SQ_STEPS = SQ_IN_W / 2;
  localparam int RQ_W     = SQ_STEPS;
  localparam int SQ_REM_W = RQ_W + 1;
  localparam int U_SHIFT  = 34;
  localparam int UNUM_W   = POS_W + U_SHIFT;
  localparam int U_W      = 31;
  localparam int Q30      = 30;
  localparam int G_W      = 33;
  localparam int H_W      = 33;
  localparam int K_W      = 63;
  localparam int KLO_W    = 32;
  localparam int KHI_W    = K_W - KLO_W;
  localparam int NF_W     = K_W + H_W;
  localparam int N_SHIFT  = 26;
  localparam int N_W      = NF_W + N_SHIFT;
  localparam int ACC_W    = 32;
  localparam int Q_STEPS  = ACC_W;
  localparam int OVF_W    = R4_W + Q_STEPS;

  localparam logic [K_W-1:0]   K_RESET     = 63'd1569550000000000000;
  localparam logic [G_W-1:0]   Q30_ONE     = G_W'(1) << Q30;
  localparam logic [G_W-1:0]   Q30_THREE   = G_W'(3) << Q30;
  localparam logic [ACC_W-1:0] ACC_POS_LIM = 32'h7fff_ffff;
  localparam logic [ACC_W-1:0] ACC_NEG_LIM = 32'h8000_0000;

  typedef struct packed {
    logic signed [POS_W-1:0] position_x;
    logic signed [POS_W-1:0] position_y;
    logic signed [POS_W-1:0] position_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;
    logic                    out_of_range;
  } out_beat_t;

  typedef struct packed {
    logic [NCOMP-1:0] neg;
    logic             zero;
  } side_t;

  typedef struct packed {
    logic [NCOMP-1:0][POS_W-1:0] mag;
    side_t                       side;
    logic [R2_W-1:0]             r2;
  } geo_t;

  typedef struct packed {
    logic [NCOMP-1:0][U_W-1:0] u;
    side_t                     side;
    logic [R2_W-1:0]           r2;
  } ratio_t;

  typedef struct packed {
    logic [NCOMP-1:0][N_W-1:0] n;
    side_t                     side;
    logic [R4_W-1:0]           r4;
  } num_t;

endpackage
`default_nettype wire

// File: rtl/core/j2gp_sqrt.sv
`default_nettype none
module j2gp_sqrt (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vld_in,
  input  wire j2gp_pkg::geo_t        geo_in,
  output logic                       vld_out,
  output j2gp_pkg::geo_t             geo_out,
  output logic [j2gp_pkg::RQ_W-1:0]  rq_out
);
  import j2gp_pkg::*;

  localparam int LAST = SQ_STEPS - 1;

  logic                vld_r  [SQ_STEPS];
  geo_t                geo_r  [SQ_STEPS];
  logic [RQ_W-1:0]     root_r [SQ_STEPS];
  logic [SQ_REM_W-1:0] rem_r  [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam int J = SQ_STEPS - 1 - k;
    logic                vld_prev;
    geo_t                geo_prev;
    logic [RQ_W-1:0]     root_prev;
    logic [SQ_REM_W-1:0] rem_prev;
    logic [SQ_IN_W-1:0]  radicand;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] test;
    logic [RQ_W-1:0]     root_nxt;
    logic [SQ_REM_W-1:0] rem_nxt;

    if (k == 0) begin : g_head
      assign vld_prev  = vld_in;
      assign geo_prev  = geo_in;
      assign root_prev = '0;
      assign rem_prev  = '0;
    end else begin : g_body
      assign vld_prev  = vld_r[k-1];
      assign geo_prev  = geo_r[k-1];
      assign root_prev = root_r[k-1];
      assign rem_prev  = rem_r[k-1];
    end

    assign radicand = {geo_prev.r2, {SQ_PAD{1'b0}}};

    always_comb begin
      trial = {rem_prev, radicand[2*J+1 -: 2]};
      test  = (SQ_REM_W+2)'({root_prev, 2'b01});
      if (trial >= test) begin
        rem_nxt  = SQ_REM_W'(trial - test);
        root_nxt = {root_prev[RQ_W-2:0], 1'b1};
      end else begin
        rem_nxt  = SQ_REM_W'(trial);
        root_nxt = {root_prev[RQ_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        geo_r[k]  <= geo_prev;
        root_r[k] <= root_nxt;
        rem_r[k]  <= rem_nxt;
      end
    end
  end

  assign vld_out = vld_r[LAST];
  assign geo_out = geo_r[LAST];
  assign rq_out  = root_r[LAST];

  // remainder never exceeds twice the root
  rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] |-> (rem_r[LAST] <= {root_r[LAST], 1'b0}))
    else $error("sqrt remainder out of bound");

endmodule
`default_nettype wire

// File: rtl/core/j2gp_udiv.sv
`default_nettype none
module j2gp_udiv (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 vld_in,
  input  wire j2gp_pkg::geo_t       geo_in,
  input  wire logic [j2gp_pkg::RQ_W-1:0] rq_in,
  output logic                      vld_out,
  output j2gp_pkg::ratio_t          ratio_out
);
  import j2gp_pkg::*;

  localparam int LAST = U_W - 1;

  logic                           vld_r  [U_W];
  side_t                          side_r [U_W];
  logic [R2_W-1:0]                r2_r   [U_W];
  logic [RQ_W-1:0]                rq_r   [U_W];
  logic [NCOMP-1:0][UNUM_W-1:0]   rem_r  [U_W];
  logic [NCOMP-1:0][U_W-1:0]      q_r    [U_W];

  for (genvar k = 0; k < U_W; k++) begin : g_step
    localparam int I = U_W - 1 - k;
    logic                         vld_prev;
    side_t                        side_prev;
    logic [R2_W-1:0]              r2_prev;
    logic [RQ_W-1:0]              rq_prev;
    logic [NCOMP-1:0][UNUM_W-1:0] rem_prev;
    logic [NCOMP-1:0][U_W-1:0]    q_prev;
    logic [UNUM_W:0]              dsh;
    logic [UNUM_W:0]              rem_ext;
    logic [NCOMP-1:0][UNUM_W-1:0] rem_nxt;
    logic [NCOMP-1:0][U_W-1:0]    q_nxt;

    if (k == 0) begin : g_head
      assign vld_prev  = vld_in;
      assign side_prev = geo_in.side;
      assign r2_prev   = geo_in.r2;
      assign rq_prev   = rq_in;
      for (genvar c = 0; c < NCOMP; c++) begin : g_num
        assign rem_prev[c] = {geo_in.mag[c], {U_SHIFT{1'b0}}};
      end
      assign q_prev = '0;
    end else begin : g_body
      assign vld_prev  = vld_r[k-1];
      assign side_prev = side_r[k-1];
      assign r2_prev   = r2_r[k-1];
      assign rq_prev   = rq_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign q_prev    = q_r[k-1];
    end

    assign dsh = (UNUM_W+1)'(rq_prev) << I;

    always_comb begin
      rem_ext = '0;
      for (int c = 0; c < NCOMP; c++) begin
        rem_ext = {1'b0, rem_prev[c]};
        if (rem_ext >= dsh) begin
          rem_nxt[c] = UNUM_W'(rem_ext - dsh);
          q_nxt[c]   = {q_prev[c][U_W-2:0], 1'b1};
        end else begin
          rem_nxt[c] = rem_prev[c];
          q_nxt[c]   = {q_prev[c][U_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_prev;
        r2_r[k]   <= r2_prev;
        rq_r[k]   <= rq_prev;
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= q_nxt;
      end
    end
  end

  assign vld_out        = vld_r[LAST];
  assign ratio_out.u    = q_r[LAST];
  assign ratio_out.side = side_r[LAST];
  assign ratio_out.r2   = r2_r[LAST];

endmodule
`default_nettype wire

// File: rtl/core/j2gp_accel.sv
`default_nettype none
module j2gp_accel (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic [j2gp_pkg::K_W-1:0]  k,
  input  wire logic                      vld_in,
  input  wire j2gp_pkg::ratio_t          ratio_in,
  output logic                           vld_out,
  output j2gp_pkg::num_t                 num_out
);
  import j2gp_pkg::*;

  localparam int SQ_W   = 2 * U_W;
  localparam int PH_W   = 2 * R2H_W;
  localparam int PROD_W = U_W + G_W;
  localparam int PP0_W  = 2 * KLO_W;
  localparam int PP1_W  = KHI_W + KLO_W;

  // stage 1: squares
  logic                      vld1_r;
  logic [NCOMP-1:0][U_W-1:0] u1_r;
  side_t                     side1_r;
  logic [SQ_W-1:0]           sq1_r;
  logic [PH_W-1:0]           phh1_r, phl1_r, pll1_r;

  // stage 2: g terms and r^4
  logic                      vld2_r;
  logic [NCOMP-1:0][U_W-1:0] u2_r;
  side_t                     side2_r;
  logic [G_W-1:0]            gxy2_r, gz2_r;
  logic                      gxy_neg2_r, gz_neg2_r;
  logic [R4_W-1:0]           r4_2_r;
  logic [U_W-1:0]            s_nxt;
  logic [G_W-1:0]            t5_nxt;
  logic [G_W-1:0]            gxy_nxt, gz_nxt;
  logic                      gxy_neg_nxt, gz_neg_nxt;

  // stage 3: h terms
  logic                      vld3_r;
  logic [NCOMP-1:0][H_W-1:0] h3_r;
  side_t                     side3_r;
  logic [R4_W-1:0]           r4_3_r;
  logic [NCOMP-1:0][H_W-1:0] h_nxt;
  logic [NCOMP-1:0]          neg3_nxt;
  logic [PROD_W-1:0]         prod_nxt;
  logic [G_W-1:0]            gsel;
  logic                      gsel_neg;

  // stage 4: partial products with k
  logic                        vld4_r;
  logic [NCOMP-1:0][PP0_W-1:0] pp0_4_r;
  logic [NCOMP-1:0][PP1_W-1:0] pp1_4_r;
  logic [NCOMP-1:0]            h1_4_r;
  side_t                       side4_r;
  logic [R4_W-1:0]             r4_4_r;

  // stage 5: numerator
  logic                      vld5_r;
  num_t                      num5_r;
  num_t                      num5_nxt;
  logic [NF_W-1:0]           nf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_in;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r    <= ratio_in.u;
      side1_r <= ratio_in.side;
      sq1_r   <= SQ_W'(ratio_in.u[2]) * SQ_W'(ratio_in.u[2]);
      phh1_r  <= PH_W'(ratio_in.r2[R2_W-1:R2H_W]) * PH_W'(ratio_in.r2[R2_W-1:R2H_W]);
      phl1_r  <= PH_W'(ratio_in.r2[R2_W-1:R2H_W]) * PH_W'(ratio_in.r2[R2H_W-1:0]);
      pll1_r  <= PH_W'(ratio_in.r2[R2H_W-1:0]) * PH_W'(ratio_in.r2[R2H_W-1:0]);
    end
  end

  always_comb begin
    s_nxt  = sq1_r[Q30 +: U_W];
    t5_nxt = (G_W'(s_nxt) << 2) + G_W'(s_nxt);
    if (t5_nxt >= Q30_ONE) begin
      gxy_nxt     = t5_nxt - Q30_ONE;
      gxy_neg_nxt = 1'b0;
    end else begin
      gxy_nxt     = Q30_ONE - t5_nxt;
      gxy_neg_nxt = 1'b1;
    end
    if (t5_nxt >= Q30_THREE) begin
      gz_nxt     = t5_nxt - Q30_THREE;
      gz_neg_nxt = 1'b0;
    end else begin
      gz_nxt     = Q30_THREE - t5_nxt;
      gz_neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u2_r       <= u1_r;
      side2_r    <= side1_r;
      gxy2_r     <= gxy_nxt;
      gz2_r      <= gz_nxt;
      gxy_neg2_r <= gxy_neg_nxt;
      gz_neg2_r  <= gz_neg_nxt;
      r4_2_r     <= (R4_W'(phh1_r) << (2 * R2H_W)) + (R4_W'(phl1_r) << (R2H_W + 1))
                    + R4_W'(pll1_r);
    end
  end

  always_comb begin
    prod_nxt = '0;
    gsel     = '0;
    gsel_neg = 1'b0;
    for (int c = 0; c < NCOMP; c++) begin
      gsel        = (c == NCOMP - 1) ? gz2_r : gxy2_r;
      gsel_neg    = (c == NCOMP - 1) ? gz_neg2_r : gxy_neg2_r;
      prod_nxt    = PROD_W'(u2_r[c]) * PROD_W'(gsel);
      h_nxt[c]    = prod_nxt[Q30 +: H_W];
      neg3_nxt[c] = side2_r.neg[c] ^ gsel_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h3_r         <= h_nxt;
      side3_r.neg  <= neg3_nxt;
      side3_r.zero <= side2_r.zero;
      r4_3_r       <= r4_2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCOMP; c++) begin
        pp0_4_r[c] <= PP0_W'(k[KLO_W-1:0]) * PP0_W'(h3_r[c][KLO_W-1:0]);
        pp1_4_r[c] <= PP1_W'(k[K_W-1:KLO_W]) * PP1_W'(h3_r[c][KLO_W-1:0]);
        h1_4_r[c]  <= h3_r[c][H_W-1];
      end
      side4_r <= side3_r;
      r4_4_r  <= r4_3_r;
    end
  end

  always_comb begin
    nf = '0;
    for (int c = 0; c < NCOMP; c++) begin
      nf = NF_W'(pp0_4_r[c]) + (NF_W'(pp1_4_r[c]) << KLO_W)
           + (h1_4_r[c] ? (NF_W'(k) << KLO_W) : '0);
      num5_nxt.n[c] = {nf, {N_SHIFT{1'b0}}};
    end
    num5_nxt.side = side4_r;
    num5_nxt.r4   = r4_4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num5_r <= num5_nxt;
    end
  end

  assign vld_out = vld5_r;
  assign num_out = num5_r;

endmodule
`default_nettype wire

// File: rtl/core/j2gp_qdiv.sv
`default_nettype none
module j2gp_qdiv (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                vld_in,
  input  wire j2gp_pkg::num_t      num_in,
  output logic                     vld_out,
  output j2gp_pkg::out_beat_t      beat_out
);
  import j2gp_pkg::*;

  logic                         vld_r  [0:Q_STEPS];
  side_t                        side_r [0:Q_STEPS];
  logic [R4_W-1:0]              r4_r   [0:Q_STEPS];
  logic [NCOMP-1:0]             ovf_r  [0:Q_STEPS];
  logic [NCOMP-1:0][N_W-1:0]    rem_r  [0:Q_STEPS];
  logic [NCOMP-1:0][ACC_W-1:0]  q_r    [1:Q_STEPS];

  logic [NCOMP-1:0] ovf_nxt;

  // quotient of 2^32 or more saturates outright
  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      ovf_nxt[c] = OVF_W'(num_in.n[c]) >= {num_in.r4, {Q_STEPS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= num_in.side;
      r4_r[0]   <= num_in.r4;
      ovf_r[0]  <= ovf_nxt;
      rem_r[0]  <= num_in.n;
    end
  end

  for (genvar k = 1; k <= Q_STEPS; k++) begin : g_step
    localparam int I = Q_STEPS - k;
    logic [NCOMP-1:0][ACC_W-1:0] q_prev;
    logic [OVF_W-1:0]            dsh;
    logic [OVF_W-1:0]            rem_ext;
    logic [NCOMP-1:0][N_W-1:0]   rem_nxt;
    logic [NCOMP-1:0][ACC_W-1:0] q_nxt;

    if (k == 1) begin : g_head
      assign q_prev = '0;
    end else begin : g_body
      assign q_prev = q_r[k-1];
    end

    assign dsh = OVF_W'(r4_r[k-1]) << I;

    always_comb begin
      rem_ext = '0;
      for (int c = 0; c < NCOMP; c++) begin
        rem_ext = OVF_W'(rem_r[k-1][c]);
        if (rem_ext >= dsh) begin
          rem_nxt[c] = N_W'(rem_ext - dsh);
          q_nxt[c]   = {q_prev[c][ACC_W-2:0], 1'b1};
        end else begin
          rem_nxt[c] = rem_r[k-1][c];
          q_nxt[c]   = {q_prev[c][ACC_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_r[k-1];
        r4_r[k]   <= r4_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= q_nxt;
      end
    end
  end

  // saturation and sign
  logic                        out_vld_r;
  out_beat_t                   out_r;
  out_beat_t                   out_nxt;
  logic [NCOMP-1:0][ACC_W-1:0] acc;
  logic [NCOMP-1:0]            sat;
  logic [ACC_W-1:0]            lim;
  logic [ACC_W-1:0]            mag;

  always_comb begin
    lim = '0;
    mag = '0;
    for (int c = 0; c < NCOMP; c++) begin
      lim    = side_r[Q_STEPS].neg[c] ? ACC_NEG_LIM : ACC_POS_LIM;
      sat[c] = ovf_r[Q_STEPS][c] || (q_r[Q_STEPS][c] > lim);
      mag    = sat[c] ? lim : q_r[Q_STEPS][c];
      acc[c] = side_r[Q_STEPS].neg[c] ? (~mag + 1'b1) : mag;
    end
    if (side_r[Q_STEPS].zero) begin
      out_nxt.accel_x      = '0;
      out_nxt.accel_y      = '0;
      out_nxt.accel_z      = '0;
      out_nxt.out_of_range = 1'b1;
    end else begin
      out_nxt.accel_x      = acc[0];
      out_nxt.accel_y      = acc[1];
      out_nxt.accel_z      = acc[2];
      out_nxt.out_of_range = |sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[Q_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign vld_out  = out_vld_r;
  assign beat_out = out_r;

  for (genvar c = 0; c < NCOMP; c++) begin : g_chk
    rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
      (vld_r[Q_STEPS] && !side_r[Q_STEPS].zero && !ovf_r[Q_STEPS][c])
      |-> (rem_r[Q_STEPS][c] < N_W'(r4_r[Q_STEPS])))
      else $error("final remainder not below divisor");
  end

  last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[Q_STEPS]) |=> out_vld_r)
    else $error("result beat lost at output stage");

endmodule
`default_nettype wire

// File: rtl/core/j2_gravity_perturbation.sv
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  in_beat_t   x, y, z position in metres
// out      out  out_valid/out_stall out_beat_t accel x, y, z and range flag
// cfg      in   cfg_valid/cfg_ready  63-bit j2 coefficient
//
// one beat per cycle in and out while no stalled result holds the pipeline; registered stages:
// (3 front stages, 32 sqrt steps, 31 ratio divide steps, 5 multiply stages,
//  1 overflow check, 32 quotient steps, 1 saturation stage)
// reset is synchronous and active low; it clears every valid bit and reloads the coefficient
// a stalled result stops the whole pipeline and raises in_stall in the same cycle
`default_nettype none
module j2_gravity_perturbation (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire j2gp_pkg::in_beat_t        in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output j2gp_pkg::out_beat_t            out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [j2gp_pkg::K_W-1:0]  cfg_data
);
  import j2gp_pkg::*;

  logic           en;
  logic [K_W-1:0] k_r;

  logic [NCOMP-1:0][POS_W-1:0] pos;

  logic                        a_vld_r;
  logic [NCOMP-1:0][POS_W-1:0] a_mag_r;
  logic [NCOMP-1:0]            a_neg_r;
  logic [NCOMP-1:0][POS_W-1:0] a_mag_nxt;
  logic [NCOMP-1:0]            a_neg_nxt;

  logic                        b_vld_r;
  logic [NCOMP-1:0][POS_W-1:0] b_mag_r;
  logic [NCOMP-1:0]            b_neg_r;
  logic [NCOMP-1:0][R2_W-1:0]  b_sq_r;

  logic c_vld_r;
  geo_t c_geo_r;
  geo_t c_geo_nxt;

  logic            sq_vld;
  geo_t            sq_geo;
  logic [RQ_W-1:0] sq_rq;

  logic   ud_vld;
  ratio_t ud_ratio;

  logic ac_vld;
  num_t ac_num;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !rst_n || !en;
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= K_RESET;
    end else if (cfg_valid && cfg_ready) begin
      k_r <= cfg_data;
    end
  end

  assign pos = {in_data.position_z, in_data.position_y, in_data.position_x};

  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      a_neg_nxt[c] = pos[c][POS_W-1];
      a_mag_nxt[c] = pos[c][POS_W-1] ? (~pos[c] + 1'b1) : pos[c];
    end
  end

  always_comb begin
    c_geo_nxt.mag       = b_mag_r;
    c_geo_nxt.side.neg  = b_neg_r;
    c_geo_nxt.r2        = b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
    c_geo_nxt.side.zero = (c_geo_nxt.r2 == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag_r <= a_mag_nxt;
      a_neg_r <= a_neg_nxt;
      b_mag_r <= a_mag_r;
      b_neg_r <= a_neg_r;
      for (int c = 0; c < NCOMP; c++) begin
        b_sq_r[c] <= R2_W'(a_mag_r[c]) * R2_W'(a_mag_r[c]);
      end
      c_geo_r <= c_geo_nxt;
    end
  end

  j2gp_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (c_vld_r),
    .geo_in  (c_geo_r),
    .vld_out (sq_vld),
    .geo_out (sq_geo),
    .rq_out  (sq_rq)
  );

  j2gp_udiv u_udiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_in    (sq_vld),
    .geo_in    (sq_geo),
    .rq_in     (sq_rq),
    .vld_out   (ud_vld),
    .ratio_out (ud_ratio)
  );

  j2gp_accel u_accel (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .k        (k_r),
    .vld_in   (ud_vld),
    .ratio_in (ud_ratio),
    .vld_out  (ac_vld),
    .num_out  (ac_num)
  );

  j2gp_qdiv u_qdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (ac_vld),
    .num_in   (ac_num),
    .vld_out  (out_valid),
    .beat_out (out_data)
  );

  beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> a_vld_r)
    else $error("accepted beat missing from first stage");

  front_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(c_vld_r))
    else $error("front stage moved during stall");

endmodule
`default_nettype wire

// File: bench/j2_gravity_perturbation_chk.sv
`default_nettype none
module j2_gravity_perturbation_chk (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic                     in_stall,
  input  wire j2gp_pkg::in_beat_t       in_data,
  input  wire logic                     out_valid,
  input  wire logic                     out_stall,
  input  wire j2gp_pkg::out_beat_t      out_data,
  input  wire logic                     cfg_valid,
  input  wire logic                     cfg_ready,
  input  wire logic [j2gp_pkg::K_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import j2gp_pkg::*;

  logic [K_W-1:0] coeff;
  out_beat_t      accel_q[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic out_beat_t j2_accel(in_beat_t p, logic [K_W-1:0] k);
    longint      c[3];
    logic [63:0] mag[3];
    logic        neg[3];
    logic [63:0] u[3];
    logic [31:0] acc[3];
    logic [63:0] r2, rq, s, gm, h;
    longint      gxy, gz, g;
    logic [127:0] n, q;
    logic [31:0] lim, m;
    logic        sat, sn;
    out_beat_t   r;
    c[0] = longint'(p.position_x);
    c[1] = longint'(p.position_y);
    c[2] = longint'(p.position_z);
    r2 = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      mag[i] = neg[i] ? -c[i] : c[i];
      r2 = r2 + mag[i] * mag[i];
    end
    if (r2 == 0) begin
      r = '0;
      r.out_of_range = 1'b1;
      return r;
    end
    rq = int_sqrt(r2 << 8);
    for (int i = 0; i < 3; i++) u[i] = (mag[i] << 34) / rq;
    s = (u[2] * u[2]) >> 30;
    gxy = 5 * longint'(s) - (longint'(1) << 30);
    gz = 5 * longint'(s) - 3 * (longint'(1) << 30);
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      g = (i == 2) ? gz : gxy;
      gm = (g < 0) ? -g : g;
      sn = neg[i] ^ (g < 0);
      h = (u[i] * gm) >> 30;
      n = (128'(k) * 128'(h)) << 26;
      q = (n / 128'(r2)) / 128'(r2);
      lim = sn ? 32'h8000_0000 : 32'h7fff_ffff;
      if (q > 128'(lim)) begin
        m = lim;
        sat = 1'b1;
      end else begin
        m = q[31:0];
      end
      acc[i] = sn ? -m : m;
    end
    r.accel_x = acc[0];
    r.accel_y = acc[1];
    r.accel_z = acc[2];
    r.out_of_range = sat;
    return r;
  endfunction

  assign pending = accel_q.size();

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      coeff <= K_RESET;
      accel_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) coeff <= cfg_data;
      if (in_valid && !in_stall) accel_q.push_back(j2_accel(in_data, coeff));
      if (out_valid && !out_stall) begin
        if (accel_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result beat %h", out_data);
        end else begin
          want = accel_q.pop_front();
          if (out_data !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected x %0d y %0d z %0d oor %b, got x %0d y %0d z %0d oor %b",
                       want.accel_x, want.accel_y, want.accel_z, want.out_of_range,
                       out_data.accel_x, out_data.accel_y, out_data.accel_z,
                       out_data.out_of_range);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: bench/j2_gravity_perturbation_tb.sv
`default_nettype none
module j2_gravity_perturbation_tb;
  import j2gp_pkg::*;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  in_beat_t       in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  out_beat_t      out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [K_W-1:0] cfg_data = '0;
  int             fail_count;
  int             pending;
  int             mode = 0;
  logic           holding = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  j2_gravity_perturbation u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  j2_gravity_perturbation_chk u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // modes: 0 none, 1 sender idle, 2 receiver stalls, 3 both lightly
  always @(posedge clk) begin
    if (holding) begin
      out_stall <= 1'b1;
    end else begin
      case (mode)
        2: out_stall <= $urandom_range(99) < 45;
        3: out_stall <= $urandom_range(99) < 9;
        default: out_stall <= 1'b0;
      endcase
    end
  end

  function automatic logic signed [POS_W-1:0] rand_coord();
    int unsigned sel;
    int unsigned sh;
    logic signed [POS_W-1:0] v;
    sel = $urandom_range(9);
    v = POS_W'($urandom);
    if (sel == 0) return '0;
    if (sel < 5) return v;
    sh = $urandom_range(POS_W - 1);
    return v >>> sh;
  endfunction

  task automatic send(input logic signed [POS_W-1:0] x, y, z);
    int unsigned idle_pct;
    idle_pct = (mode == 1) ? 45 : (mode == 3) ? 9 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{position_x: x, position_y: y, position_z: z};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_coeff(input logic [K_W-1:0] k);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (110) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(input int count);
    for (int i = 0; i < count; i++) send(rand_coord(), rand_coord(), rand_coord());
  endtask

  localparam logic signed [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed beats at the reset coefficient
    send(0, 0, 0);
    send(PMAX, PMAX, PMAX);
    send(PMIN, PMIN, PMIN);
    send(PMIN, PMAX, PMIN);
    send(PMAX, 0, 0);
    send(0, PMIN, 0);
    send(0, 0, PMAX);
    send(0, 0, PMIN);
    send(6378137, 0, 0);
    send(0, 6378137, 0);
    send(0, 0, 6356752);
    send(4500000, -3000000, 4000000);
    send(2, 0, 1);
    send(-2, 0, 1);
    send(1, 0, 0);
    send(0, 0, -1);
    send(-1, 1, -1);
    send(-1, -1, -1);
    send(1000, -1000, 500);
    send(7000000, 7000000, -100);
    write_coeff({K_W{1'b1}});
    random_items(150);
    write_coeff('0);
    mode = 2;
    random_items(150);
    write_coeff(K_W'(1));
    mode = 1;
    random_items(150);
    write_coeff(K_RESET);
    mode = 3;
    random_items(300);
    mode = 0;
    fork
      random_items(200);
      begin
        repeat (20) @(posedge clk);
        holding = 1'b1;
        repeat (300) @(posedge clk);
        holding = 1'b0;
      end
    join
    write_coeff(K_W'({$urandom, $urandom}));
    mode = 2;
    random_items(250);
    mode = 1;
    random_items(250);
    in_valid <= 1'b0;
    mode = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (fail_count == 0) $display("** j2_gravity_perturbation: PASSED **");
    else $display("** j2_gravity_perturbation: FAILED **");
    $finish;
  end

  initial begin
    #4000000;
    $display("** j2_gravity_perturbation: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
